[rtl/decimal_morse_digit_sender_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the decimal Morse digit sender.
// Each macro takes a label, the clock, the reset and the two expressions.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_MORSE_DIGIT_SENDER_CORE_ASSERT_SVH
`define DECIMAL_MORSE_DIGIT_SENDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DMDS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmds assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DMDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmds assertion failed");

`endif

[rtl/dmds_pkg.sv]
// ---------------------------------------------------------------------------
// dmds_pkg
// Constants, types, microcode ROM and symbol table for the Morse sender.
// ---------------------------------------------------------------------------
`default_nettype none

package dmds_pkg;

  // Field widths and limits.
  localparam int VALUE_W        = 16;
  localparam int TICK_W         = 8;
  localparam int DIGIT_W        = 4;
  localparam int MAX_DIGITS     = 5;
  localparam int SYMS_PER_DIGIT = 5;
  localparam int CNT_W          = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W          = $clog2(MAX_DIGITS);
  localparam int SYM_W          = $clog2(SYMS_PER_DIGIT);
  localparam int CFG_IDX_W      = 2;

  localparam logic [TICK_W-1:0] SHORT_RESET = 8'd10;
  localparam logic [TICK_W-1:0] LONG_RESET  = 8'd50;

  // Divide by ten through a reciprocal: exact for every 16-bit value.
  localparam logic [VALUE_W-1:0] DIV10_MUL   = 16'd52429;
  localparam int                 DIV10_SHIFT = 19;
  localparam int                 PROD_W      = 2 * VALUE_W;
  localparam int                 QUOT_W      = PROD_W - DIV10_SHIFT;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_DIGITS);
  localparam logic [SYM_W-1:0] SYM_LAST = SYM_W'(SYMS_PER_DIGIT - 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_TICKS = 2'd0,
    REG_LONG_TICKS  = 2'd1
  } cfg_reg_t;

  // Datapath operation of a microcode step.
  typedef enum logic [1:0] {
    OP_WAIT_IN,
    OP_DIV_STEP,
    OP_SELECT,
    OP_EMIT
  } op_t;

  // Branch condition of a microcode step.
  typedef enum logic [1:0] {
    COND_IN_ACCEPT,
    COND_DIV_DONE,
    COND_NO_DIGITS,
    COND_LAST_SYM
  } cond_t;

  typedef logic [1:0] step_t;

  localparam step_t STEP_IDLE   = 2'd0;
  localparam step_t STEP_DIV    = 2'd1;
  localparam step_t STEP_SELECT = 2'd2;
  localparam step_t STEP_EMIT   = 2'd3;

  // One control word: operation, condition and both branch targets.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } ctl_word_t;

  // Microcode program.
  function automatic ctl_word_t ucode_rom(step_t s);
    ctl_word_t w;
    unique case (s)
      STEP_IDLE:   w = '{OP_WAIT_IN,  COND_IN_ACCEPT, STEP_DIV,  STEP_IDLE};
      STEP_DIV:    w = '{OP_DIV_STEP, COND_DIV_DONE,  STEP_SELECT, STEP_DIV};
      STEP_SELECT: w = '{OP_SELECT,   COND_NO_DIGITS, STEP_IDLE, STEP_EMIT};
      STEP_EMIT:   w = '{OP_EMIT,     COND_LAST_SYM,  STEP_IDLE, STEP_EMIT};
      default:     w = '{OP_WAIT_IN,  COND_IN_ACCEPT, STEP_DIV,  STEP_IDLE};
    endcase
    return w;
  endfunction

  // Symbol kind for a digit at a given position within its five symbols.
  function automatic logic sym_is_dash(logic [DIGIT_W-1:0] d, logic [SYM_W-1:0] pos);
    logic [DIGIT_W-1:0] lead;
    logic [DIGIT_W-1:0] pos_ext;
    pos_ext = DIGIT_W'(pos);
    if (d >= 4'd1 && d <= 4'd5) begin
      return pos_ext >= d;
    end
    lead = (d == 4'd0) ? 4'd5 : d - 4'd5;
    return pos_ext < lead;
  endfunction

endpackage

`default_nettype wire

[rtl/dmds_if.sv]
// ---------------------------------------------------------------------------
// dmds interfaces
// Valid/ready channels for values in, symbols out and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

// Input channel: one value per beat.
interface dmds_in_if import dmds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// Output channel: one Morse symbol per beat.
interface dmds_out_if import dmds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_dash;
  logic [TICK_W-1:0]  on_ticks;
  logic [TICK_W-1:0]  off_ticks;
  logic [DIGIT_W-1:0] digit_value;
  logic               last_symbol;
  modport source (output valid, output is_dash, output on_ticks, output off_ticks,
                  output digit_value, output last_symbol, input ready);
  modport sink   (input valid, input is_dash, input on_ticks, input off_ticks,
                  input digit_value, input last_symbol, output ready);
endinterface

// Configuration write channel: register index and data per beat.
interface dmds_cfg_if import dmds_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TICK_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/decimal_morse_digit_sender_core.sv]
// ---------------------------------------------------------------------------
// decimal_morse_digit_sender_core
// Splits a 16-bit value into decimal digits and sends each digit as five
// Morse symbols, most significant digit first, with LED tick durations.
//
//   channel  dir  beat carries
//   in_ch    in   value
//   out_ch   out  is_dash, on_ticks, off_ticks, digit_value, last_symbol
//   cfg      in   index, data (0 short_ticks, 1 long_ticks)
//
// A value is taken in the idle step, divided by ten once per digit until it
// reaches zero or five digits, then a select step picks the top digit and
// the symbol step sends five symbols per digit. A zero value sends none.
// The divide step is one 16x16 reciprocal multiply per digit.
// Synchronous reset restores the tick registers to 10 and 50 and returns
// the sequencer to its idle step. A stalled sink holds the symbol step.
// ---------------------------------------------------------------------------
`default_nettype none
`include "decimal_morse_digit_sender_core_assert.svh"

module decimal_morse_digit_sender_core
  import dmds_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  dmds_in_if.sink     in_ch,
  dmds_out_if.source  out_ch,
  dmds_cfg_if.sink    cfg
);

  // Sequencer state.
  step_t     step;
  step_t     step_next;
  ctl_word_t ctl;
  logic      cond_true;
  logic      stall;

  // Datapath registers.
  logic [VALUE_W-1:0] value_reg;
  logic [CNT_W-1:0]   count;
  logic [DIGIT_W-1:0] digits [MAX_DIGITS];
  logic [IDX_W-1:0]   idx;
  logic [SYM_W-1:0]   sym;
  logic [TICK_W-1:0]  short_ticks;
  logic [TICK_W-1:0]  long_ticks;

  // Output register.
  logic               out_valid;
  logic               out_is_dash;
  logic [TICK_W-1:0]  out_ticks;
  logic [DIGIT_W-1:0] out_digit;
  logic               out_last;
  logic               out_free;

  // Datapath combinational values.
  logic               in_accept;
  logic               div_done;
  logic               last_sym;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] quot_x10;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] cur_digit;
  logic               cur_dash;
  logic [TICK_W-1:0]  cur_ticks;

  // Configuration port takes a beat whenever reset is low.
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks <= SHORT_RESET;
      long_ticks  <= LONG_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_SHORT_TICKS) begin
        short_ticks <= cfg.data;
      end else if (cfg.index == REG_LONG_TICKS) begin
        long_ticks <= cfg.data;
      end
    end
  end

  // Fetch the control word of the current step.
  assign ctl       = ucode_rom(step);
  assign in_ch.ready = !rst && (ctl.op == OP_WAIT_IN);
  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid || out_ch.ready;
  assign stall     = (ctl.op == OP_EMIT) && !out_free;

  // Divide by ten: reciprocal multiply, then remainder by shift-add.
  assign prod     = PROD_W'(value_reg) * PROD_W'(DIV10_MUL);
  assign quot     = VALUE_W'(prod[PROD_W-1:DIV10_SHIFT]);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem      = DIGIT_W'(value_reg - quot_x10);

  assign div_done = (value_reg == '0) || (count == CNT_MAX);
  assign last_sym = (sym == SYM_LAST) && (idx == '0);

  // Current symbol.
  assign cur_digit = digits[idx];
  assign cur_dash  = sym_is_dash(cur_digit, sym);
  always_comb begin
    cur_ticks = cur_dash ? long_ticks : short_ticks;
    if (cur_ticks == '0) begin
      cur_ticks = TICK_W'(1);
    end
  end

  // Branch condition selection.
  always_comb begin
    unique case (ctl.cond)
      COND_IN_ACCEPT: cond_true = in_accept;
      COND_DIV_DONE:  cond_true = div_done;
      COND_NO_DIGITS: cond_true = (count == '0);
      COND_LAST_SYM:  cond_true = last_sym;
      default:        cond_true = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    if (stall) begin
      step_next = step;
    end else if (cond_true) begin
      step_next = ctl.tgt_true;
    end else begin
      step_next = ctl.tgt_false;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Datapath actions driven by the control word.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (ctl.op)
        OP_WAIT_IN: begin
          if (in_accept) begin
            value_reg <= in_ch.value;
            count     <= '0;
          end
        end
        OP_DIV_STEP: begin
          if (!div_done) begin
            digits[count[IDX_W-1:0]] <= rem;
            value_reg                <= quot;
            count                    <= count + CNT_W'(1);
          end
        end
        OP_SELECT: begin
          idx <= IDX_W'(count - CNT_W'(1));
          sym <= '0;
        end
        OP_EMIT: begin
          if (!stall) begin
            if (sym == SYM_LAST) begin
              sym <= '0;
              idx <= idx - IDX_W'(1);
            end else begin
              sym <= sym + SYM_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: loaded by a symbol step, freed by a sink beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.op == OP_EMIT && !stall) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_EMIT && !stall) begin
      out_is_dash <= cur_dash;
      out_ticks   <= cur_ticks;
      out_digit   <= cur_digit;
      out_last    <= last_sym;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.is_dash     = out_is_dash;
  assign out_ch.on_ticks    = out_ticks;
  assign out_ch.off_ticks   = out_ticks;
  assign out_ch.digit_value = out_digit;
  assign out_ch.last_symbol = out_last;

  // A new value always starts with an empty digit buffer.
  `DMDS_ASSERT_NEXT(a_load_clears, clk, rst, in_accept, count == '0 && step == STEP_DIV)
  // Symbol steps only read digits that the divide steps wrote.
  `DMDS_ASSERT_IMPLY(a_emit_idx, clk, rst, step == STEP_EMIT,
                     count != '0 && CNT_W'(idx) < count)
  // A pending symbol never carries a non-decimal digit or a zero tick count.
  `DMDS_ASSERT_IMPLY(a_out_sane, clk, rst, out_valid,
                     out_digit <= 4'd9 && out_ticks != '0)
  // The final symbol sends the sequencer back to idle.
  `DMDS_ASSERT_NEXT(a_last_idle, clk, rst, step == STEP_EMIT && !stall && last_sym,
                    step == STEP_IDLE)

endmodule

`default_nettype wire

[tb/morse_symbol_checker.sv]
// ----------------------------------------------------------------------------
// Morse symbol checker
// Watches the value, symbol and register write channels of the Morse digit
// sender. It keeps its own copy of the tick registers, works out the symbols
// that each accepted value must produce, and compares every accepted symbol
// beat with the oldest outstanding symbol.
// ----------------------------------------------------------------------------
module morse_symbol_checker
  import dmds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dmds_in_if   in_ch,
  dmds_out_if  out_ch,
  dmds_cfg_if  cfg,
  output int   mismatches,
  output int   pending,
  output int   symbols_checked
);

  // One Morse symbol as it appears on the output channel.
  typedef struct packed {
    logic               is_dash;
    logic [TICK_W-1:0]  on_ticks;
    logic [TICK_W-1:0]  off_ticks;
    logic [DIGIT_W-1:0] digit_value;
    logic               last_symbol;
  } morse_symbol_t;

  morse_symbol_t     symbol_q[$];
  logic [TICK_W-1:0] dot_ticks;
  logic [TICK_W-1:0] dash_ticks;
  int                fail_count;
  int                checked_count;

  // A tick register holding zero behaves as one.
  function automatic logic [TICK_W-1:0] at_least_one(logic [TICK_W-1:0] t);
    return (t == '0) ? TICK_W'(1) : t;
  endfunction

  // Queue the five symbols of each decimal digit, most significant first.
  task automatic queue_symbols_for(input logic [VALUE_W-1:0] value);
    logic [DIGIT_W-1:0] digits [MAX_DIGITS];
    int unsigned        rest;
    int                 count;
    int                 lead;
    morse_symbol_t      sym;
    rest  = value;
    count = 0;
    while (rest != 0 && count < MAX_DIGITS) begin
      digits[count] = DIGIT_W'(rest % 10);
      rest          = rest / 10;
      count++;
    end
    for (int i = count - 1; i >= 0; i--) begin
      for (int s = 0; s < SYMS_PER_DIGIT; s++) begin
        // Digits one to five lead with dots; the others lead with dashes.
        if (digits[i] >= 4'd1 && digits[i] <= 4'd5) begin
          sym.is_dash = (s >= int'(digits[i]));
        end else begin
          lead        = (int'(digits[i]) + 5) % 10;
          sym.is_dash = (s < lead);
        end
        sym.on_ticks    = sym.is_dash ? at_least_one(dash_ticks) : at_least_one(dot_ticks);
        sym.off_ticks   = sym.on_ticks;
        sym.digit_value = digits[i];
        sym.last_symbol = (i == 0) && (s == SYMS_PER_DIGIT - 1);
        symbol_q.push_back(sym);
      end
    end
  endtask

  // Track register writes, predict on value beats, compare on symbol beats.
  always @(posedge clk) begin
    morse_symbol_t seen;
    morse_symbol_t want;
    if (rst) begin
      dot_ticks  = SHORT_RESET;
      dash_ticks = LONG_RESET;
      symbol_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_SHORT_TICKS: begin
            dot_ticks = cfg.data;
          end
          REG_LONG_TICKS: begin
            dash_ticks = cfg.data;
          end
          default: begin
          end
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.is_dash, out_ch.on_ticks, out_ch.off_ticks,
                 out_ch.digit_value, out_ch.last_symbol};
        if (symbol_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected symbol beat dash=%0b on=%0d off=%0d digit=%0d last=%0b",
                   $time, seen.is_dash, seen.on_ticks, seen.off_ticks,
                   seen.digit_value, seen.last_symbol);
        end else begin
          want = symbol_q.pop_front();
          checked_count++;
          if (seen !== want) begin
            fail_count++;
            $display("%0t: symbol differs, expected dash=%0b on=%0d off=%0d digit=%0d last=%0b",
                     $time, want.is_dash, want.on_ticks, want.off_ticks,
                     want.digit_value, want.last_symbol);
            $display("%0t:                 actual dash=%0b on=%0d off=%0d digit=%0d last=%0b",
                     $time, seen.is_dash, seen.on_ticks, seen.off_ticks,
                     seen.digit_value, seen.last_symbol);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        queue_symbols_for(in_ch.value);
      end
    end
    mismatches      <= fail_count;
    pending         <= symbol_q.size();
    symbols_checked <= checked_count;
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Testbench top for the decimal Morse digit sender
// Drives values and tick register writes with random gaps and output stalls,
// while a checker instance predicts and compares every symbol beat. Register
// writes happen only once the sender has gone quiet.
// ----------------------------------------------------------------------------
module tb_top;
  import dmds_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 65;

  // Register indexes that the sender does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_STRAY_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRAY_HI = 2'd3;

  localparam logic [VALUE_W-1:0] DIRECTED_VALUES [20] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8, 16'd9,
    16'd10, 16'd65535, 16'd12345, 16'd54321, 16'd60789, 16'd9876,
    16'd10000, 16'd40506, 16'd0, 16'd32768
  };

  logic clk = 1'b0;
  logic rst;

  dmds_in_if  in_ch();
  dmds_out_if out_ch();
  dmds_cfg_if cfg();

  int mismatches;
  int pending;
  int symbols_checked;
  int values_sent;
  int zero_values;
  int settings_used;
  int quiet_cycles;
  int stall_left;
  bit calm;
  bit in_hold;

  always #5 clk = ~clk;

  decimal_morse_digit_sender_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  morse_symbol_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg             (cfg),
    .mismatches      (mismatches),
    .pending         (pending),
    .symbols_checked (symbols_checked)
  );

  // Gap length: mostly none or short, now and then long; none while calm.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Values weighted toward every digit count, with some zeros.
  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return VALUE_W'($urandom);
    if (r < 55) return VALUE_W'($urandom_range(1, 9));
    if (r < 70) return VALUE_W'($urandom_range(10, 999));
    if (r < 85) return VALUE_W'($urandom_range(1000, 9999));
    if (r < 93) return VALUE_W'($urandom_range(10000, 65535));
    return '0;
  endfunction

  // Tick settings with extra weight on zero, one and the top value.
  function automatic logic [TICK_W-1:0] pick_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return TICK_W'(1);
    if (r < 35) return '1;
    return TICK_W'($urandom_range(0, 255));
  endfunction

  // Offer one value and wait for its beat, then maybe leave a gap.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_hold = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    values_sent++;
    if (v == '0) zero_values++;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_hold = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every predicted symbol has arrived and the sender is quiet.
  task automatic settle();
    if (in_hold) begin
      in_ch.valid <= 1'b0;
      in_hold = 1'b0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write beat; valid stays up when another write follows.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data,
                           input bit last);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    if (last) cfg.valid <= 1'b0;
  endtask

  // New tick setting, optionally preceded by a write to an undecoded index.
  task automatic set_ticks(input logic [TICK_W-1:0] dot, input logic [TICK_W-1:0] dash,
                           input bit stray);
    settle();
    if (stray) begin
      write_reg($urandom_range(0, 1) ? REG_STRAY_HI : REG_STRAY_LO, TICK_W'($urandom), 1'b0);
    end
    write_reg(REG_SHORT_TICKS, dot, 1'b0);
    write_reg(REG_LONG_TICKS, dash, 1'b1);
    settings_used++;
  endtask

  // Output ready with random stalls, held high during calm stretches.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= gap_len();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed values, directed tick extremes, then random phases.
  initial begin
    rst          <= 1'b1;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    cfg.valid    <= 1'b0;
    cfg.index    <= REG_SHORT_TICKS;
    cfg.data     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset tick values first, over every digit and the field extremes.
    foreach (DIRECTED_VALUES[k]) begin
      send_value(DIRECTED_VALUES[k]);
    end

    // Tick extremes, a zero setting that must read as one, a stray index.
    set_ticks(TICK_W'(1), '1, 1'b0);
    send_value(16'd65535);
    set_ticks('1, TICK_W'(1), 1'b1);
    send_value(16'd12345);
    set_ticks('0, '0, 1'b1);
    send_value(16'd50617);
    send_value(16'd0);

    for (int p = 0; p < PHASES; p++) begin
      set_ticks(pick_ticks(), pick_ticks(), $urandom_range(0, 2) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
        send_value(pick_value());
      end
    end
    calm = 1'b0;

    settle();
    $display("Run sent %0d values (%0d of them zero) under %0d tick settings.",
             values_sent, zero_values, settings_used + 1);
    $display("%0d symbol beats were compared.", symbols_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending != 0) $display("%0d predicted symbols never arrived", pending);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/dmds_pkg.sv
rtl/dmds_if.sv
rtl/decimal_morse_digit_sender_core.sv
tb/morse_symbol_checker.sv
tb/tb_top.sv
